// ===== rtl/tvsc_pkg.sv =====
// shared types, constants and sine table for the three-voice stereo chorus
package tvsc_pkg;

   localparam int DELAY_DEPTH    = 4096;
   localparam int DELAY_AW       = $clog2(DELAY_DEPTH);
   localparam int SINE_ENTRIES   = 1024;
   localparam int SINE_AW        = $clog2(SINE_ENTRIES);
   localparam int SAMPLE_BITS    = 24;

   localparam int SINE_BITS      = 16;
   localparam int SINE_SHIFT     = SINE_BITS - 1;
   localparam int FRAC_BITS      = 8;
   localparam int DELAY_BITS     = 20;
   localparam int PHASE_BITS     = 32;
   localparam int WET_BITS       = 16;
   localparam int MIX_SHIFT      = 15;
   localparam int MIXW_BITS      = MIX_SHIFT + 1;
   localparam int MIX_ONE        = 1 << MIX_SHIFT;

   localparam int NVOICES        = 3;
   localparam int VOICE_BITS     = $clog2(NVOICES);
   localparam int INVERT_VOICE   = 1;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_DELAY = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MOD_DEPTH  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WET_MIX    = 2'd3;
   localparam logic [DELAY_BITS-1:0]     BASE_DELAY_RST = DELAY_BITS'(12288);

   // datapath widths
   localparam int MPROD_BITS   = SINE_BITS + DELAY_BITS + 1;
   localparam int LFO_OFF_BITS = MPROD_BITS - SINE_SHIFT;
   localparam int TAPD_BITS    = DELAY_AW + FRAC_BITS;
   localparam int DSUM_BITS    = ((DELAY_BITS > TAPD_BITS) ? DELAY_BITS : TAPD_BITS) + 2;
   localparam int WGT_BITS     = FRAC_BITS + 2;
   localparam int ACC_BITS     = SAMPLE_BITS + FRAC_BITS + 2;
   localparam int SUM_BITS     = SAMPLE_BITS + 2;
   localparam int MAG_BITS     = SUM_BITS - 1;
   localparam int RECIP_SHIFT  = MAG_BITS + 1;
   localparam int QPROD_BITS   = MAG_BITS + RECIP_SHIFT;
   localparam int MIX_BITS     = SUM_BITS + MIXW_BITS + 1;
   localparam int OUT_BITS     = MIX_BITS - MIX_SHIFT;

   localparam logic [RECIP_SHIFT-1:0] RECIP3 =
      RECIP_SHIFT'(((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3);

   localparam logic signed [DSUM_BITS-1:0] DEL_LO = DSUM_BITS'(1 << FRAC_BITS);
   localparam logic signed [DSUM_BITS-1:0] DEL_HI =
      DSUM_BITS'((DELAY_DEPTH - 1) << FRAC_BITS);
   localparam logic [WGT_BITS-1:0]         WGT_ONE = WGT_BITS'(1 << FRAC_BITS);

   localparam logic signed [MIX_BITS-1:0] MIX_ROUND = MIX_BITS'(1 << (MIX_SHIFT - 1));
   localparam logic signed [OUT_BITS-1:0] OUT_MAX =
      OUT_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [OUT_BITS-1:0] OUT_MIN = -OUT_MAX - OUT_BITS'(1);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [SINE_BITS-1:0]   sine_type;
   typedef sine_type                      sine_tab_type [SINE_ENTRIES];
   typedef logic [PHASE_BITS-1:0]         phase_arr_type [NVOICES];

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   localparam phase_arr_type PHASE_INIT = '{32'h0000_0000, 32'h5555_5555, 32'hAAAA_AAAA};

   typedef struct packed {
      logic [DELAY_BITS-1:0] base_delay;
      logic [DELAY_BITS-1:0] mod_depth;
      logic [PHASE_BITS-1:0] phase_step;
      logic [MIXW_BITS-1:0]  wet;
      logic [MIXW_BITS-1:0]  dry;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SINE,
      ST_MUL,
      ST_ADDR,
      ST_RD0,
      ST_RD1,
      ST_DIV,
      ST_WET,
      ST_OUT
   } state_type;

   // quarter-turn polynomial sine, evaluated at elaboration
   function automatic sine_tab_type build_sine_tab();
      sine_tab_type tab;
      logic [63:0]  u;
      logic [63:0]  r;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  t;
      logic [63:0]  s;
      logic [63:0]  mag;
      logic [1:0]   q;
      for (int k = 0; k < SINE_ENTRIES; k++) begin
         u = (64'(k) << 32) / SINE_ENTRIES;
         q = u[31:30];
         r = u & ((64'd1 << 30) - 64'd1);
         if (q[0]) begin
            r = (64'd1 << 30) - r;
         end
         x   = (r * 64'd1686629713) >> 30;
         x2  = (x * x) >> 30;
         t   = (64'd1 << 30) - x2 / 64'd110;
         t   = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
         t   = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
         t   = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
         t   = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
         s   = (x * t) >> 30;
         mag = (s + (64'd1 << 14)) >> 15;
         if (mag > 64'd32767) begin
            mag = 64'd32767;
         end
         tab[k] = q[1] ? -sine_type'(mag[SINE_BITS-1:0]) : sine_type'(mag[SINE_BITS-1:0]);
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine_tab();

endpackage

// ===== rtl/tvsc_if.sv =====
// valid/ready channel interfaces for the chorus input and result words
interface tvsc_req_if;
   logic                  valid;
   logic                  ready;
   tvsc_pkg::sample_type  sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

interface tvsc_rsp_if;
   logic                  valid;
   logic                  ready;
   tvsc_pkg::sample_type  left_out;
   tvsc_pkg::sample_type  right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// ===== rtl/tvsc_delay_ram.sv =====
// single-port-write, single-port-read synchronous ram for the delay line
module tvsc_delay_ram #(
   parameter int   DEPTH     = 4096,
   parameter int   WIDTH     = 24,
   localparam int  ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tvsc_csr.sv =====
// configuration registers with wet share clamp and dry share derivation
module tvsc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [tvsc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tvsc_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output tvsc_pkg::cfg_type                    cfg
);

   logic [tvsc_pkg::DELAY_BITS-1:0] base_ff;
   logic [tvsc_pkg::DELAY_BITS-1:0] depth_ff;
   logic [tvsc_pkg::PHASE_BITS-1:0] step_ff;
   logic [tvsc_pkg::WET_BITS-1:0]   wet_ff;
   logic [tvsc_pkg::MIXW_BITS-1:0]  wet_clamped;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= tvsc_pkg::BASE_DELAY_RST;
         depth_ff <= '0;
         step_ff  <= '0;
         wet_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            tvsc_pkg::CSR_BASE_DELAY: base_ff  <= csr_wdata[tvsc_pkg::DELAY_BITS-1:0];
            tvsc_pkg::CSR_MOD_DEPTH:  depth_ff <= csr_wdata[tvsc_pkg::DELAY_BITS-1:0];
            tvsc_pkg::CSR_PHASE_STEP: step_ff  <= csr_wdata[tvsc_pkg::PHASE_BITS-1:0];
            tvsc_pkg::CSR_WET_MIX:    wet_ff   <= csr_wdata[tvsc_pkg::WET_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (wet_ff > tvsc_pkg::WET_BITS'(tvsc_pkg::MIX_ONE)) begin
         wet_clamped = tvsc_pkg::MIXW_BITS'(tvsc_pkg::MIX_ONE);
      end else begin
         wet_clamped = tvsc_pkg::MIXW_BITS'(wet_ff);
      end
   end

   assign cfg.base_delay = base_ff;
   assign cfg.mod_depth  = depth_ff;
   assign cfg.phase_step = step_ff;
   assign cfg.wet        = wet_clamped;
   assign cfg.dry        = tvsc_pkg::MIXW_BITS'(tvsc_pkg::MIX_ONE) - wet_clamped;

endmodule

// ===== rtl/tvsc_core.sv =====
// chorus sequencer: lfo, tap address, interpolated delay-line reads and dry/wet mix
module tvsc_core (
   input  logic               clock,
   input  logic               reset,
   input  tvsc_pkg::cfg_type  cfg,
   tvsc_req_if.sink           req_ch,
   tvsc_rsp_if.source         rsp_ch
);

   typedef struct packed {
      logic take_ok;
      logic sine;
      logic mul;
      logic addr;
      logic rd0;
      logic rd1;
      logic div;
      logic wet;
      logic out;
   } ctl_type;

   ctl_type ctl;

   tvsc_pkg::state_type state_ff, state_in;
   logic [tvsc_pkg::VOICE_BITS-1:0] voice_ff, voice_in;
   logic                            chan_ff, chan_in;
   logic [tvsc_pkg::DELAY_AW-1:0]   wi_ff, wi_in;
   logic                            wrap_ff, wrap_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   tvsc_pkg::phase_arr_type         phase_ff, phase_in;

   tvsc_pkg::sample_type                    x_ff;
   tvsc_pkg::sine_type                      sine_ff;
   logic signed [tvsc_pkg::MIX_BITS-1:0]    dry_prod_ff;
   logic signed [tvsc_pkg::MPROD_BITS-1:0]  mprod_ff;
   logic [tvsc_pkg::FRAC_BITS-1:0]          frac_ff;
   logic [tvsc_pkg::DELAY_AW-1:0]           p1_ff;
   logic                                    vld0_ff;
   logic                                    vld1_ff;
   logic signed [tvsc_pkg::ACC_BITS-1:0]    acc_ff;
   logic signed [tvsc_pkg::SUM_BITS-1:0]    sum_l_ff;
   logic signed [tvsc_pkg::SUM_BITS-1:0]    sum_r_ff;
   logic [tvsc_pkg::QPROD_BITS-1:0]         qprod_ff;
   logic                                    qneg_ff;
   logic signed [tvsc_pkg::MIX_BITS-1:0]    wet_prod_ff;
   tvsc_pkg::sample_type                    left_ff;
   tvsc_pkg::sample_type                    rsp_left_ff;
   tvsc_pkg::sample_type                    rsp_right_ff;

   logic take;
   logic out_free;
   logic finish;
   logic last_voice;

   logic signed [tvsc_pkg::LFO_OFF_BITS-1:0] lfo_off;
   logic signed [tvsc_pkg::DSUM_BITS-1:0]    del_sum;
   logic [tvsc_pkg::TAPD_BITS-1:0]           del_c;
   logic [tvsc_pkg::DELAY_AW-1:0]            p0;
   logic [tvsc_pkg::DELAY_AW-1:0]            p1;
   logic [tvsc_pkg::DELAY_AW-1:0]            rd_addr;
   logic [tvsc_pkg::SAMPLE_BITS-1:0]         rd_data;
   tvsc_pkg::sample_type                     d_masked;
   logic signed [tvsc_pkg::WGT_BITS-1:0]     wgt_lo;
   logic signed [tvsc_pkg::WGT_BITS-1:0]     wgt_hi;
   logic signed [tvsc_pkg::ACC_BITS-1:0]     tap_sum;
   logic signed [tvsc_pkg::SUM_BITS-1:0]     tap;
   logic signed [tvsc_pkg::SUM_BITS-1:0]     div_sel;
   logic signed [tvsc_pkg::SUM_BITS-1:0]     div_abs;
   logic [tvsc_pkg::MAG_BITS-1:0]            quo;
   logic signed [tvsc_pkg::SUM_BITS-1:0]     quo_pos;
   logic signed [tvsc_pkg::SUM_BITS-1:0]     quo_s;
   logic signed [tvsc_pkg::MIX_BITS-1:0]     mix_tot;
   logic signed [tvsc_pkg::OUT_BITS-1:0]     mix_q;
   tvsc_pkg::sample_type                     mix_sat;

   // state machine outputs
   always_comb begin
      ctl = '0;
      unique case (state_ff)
         tvsc_pkg::ST_IDLE: ctl.take_ok = 1'b1;
         tvsc_pkg::ST_SINE: ctl.sine    = 1'b1;
         tvsc_pkg::ST_MUL:  ctl.mul     = 1'b1;
         tvsc_pkg::ST_ADDR: ctl.addr    = 1'b1;
         tvsc_pkg::ST_RD0:  ctl.rd0     = 1'b1;
         tvsc_pkg::ST_RD1:  ctl.rd1     = 1'b1;
         tvsc_pkg::ST_DIV:  ctl.div     = 1'b1;
         tvsc_pkg::ST_WET:  ctl.wet     = 1'b1;
         tvsc_pkg::ST_OUT:  ctl.out     = 1'b1;
         default: ;
      endcase
   end

   assign take       = req_ch.valid && ctl.take_ok;
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign finish     = ctl.out && chan_ff && out_free;
   assign last_voice = (voice_ff == tvsc_pkg::VOICE_BITS'(tvsc_pkg::NVOICES - 1));

   // state machine next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tvsc_pkg::ST_IDLE: if (take) state_in = tvsc_pkg::ST_SINE;
         tvsc_pkg::ST_SINE: state_in = tvsc_pkg::ST_MUL;
         tvsc_pkg::ST_MUL:  state_in = tvsc_pkg::ST_ADDR;
         tvsc_pkg::ST_ADDR: state_in = tvsc_pkg::ST_RD0;
         tvsc_pkg::ST_RD0:  state_in = tvsc_pkg::ST_RD1;
         tvsc_pkg::ST_RD1:  state_in = last_voice ? tvsc_pkg::ST_DIV : tvsc_pkg::ST_SINE;
         tvsc_pkg::ST_DIV:  state_in = tvsc_pkg::ST_WET;
         tvsc_pkg::ST_WET:  state_in = tvsc_pkg::ST_OUT;
         tvsc_pkg::ST_OUT: begin
            if (!chan_ff) begin
               state_in = tvsc_pkg::ST_DIV;
            end else if (out_free) begin
               state_in = tvsc_pkg::ST_IDLE;
            end
         end
         default: state_in = tvsc_pkg::ST_IDLE;
      endcase
   end

   // control register next values
   always_comb begin
      voice_in     = voice_ff;
      chan_in      = chan_ff;
      wi_in        = wi_ff;
      wrap_in      = wrap_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         voice_in = '0;
         chan_in  = 1'b0;
      end
      if (ctl.rd1) begin
         phase_in[voice_ff] = phase_ff[voice_ff] + cfg.phase_step;
         if (!last_voice) begin
            voice_in = voice_ff + tvsc_pkg::VOICE_BITS'(1);
         end
      end
      if (ctl.out && !chan_ff) begin
         chan_in = 1'b1;
      end
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
         wi_in        = wi_ff + tvsc_pkg::DELAY_AW'(1);
         if (wi_ff == tvsc_pkg::DELAY_AW'(tvsc_pkg::DELAY_DEPTH - 1)) begin
            wrap_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tvsc_pkg::ST_IDLE;
         voice_ff     <= '0;
         chan_ff      <= 1'b0;
         wi_ff        <= '0;
         wrap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= tvsc_pkg::PHASE_INIT;
      end else begin
         state_ff     <= state_in;
         voice_ff     <= voice_in;
         chan_ff      <= chan_in;
         wi_ff        <= wi_in;
         wrap_ff      <= wrap_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   // tap address from lfo-modulated delay
   always_comb begin
      lfo_off = mprod_ff[tvsc_pkg::MPROD_BITS-1:tvsc_pkg::SINE_SHIFT];
      del_sum = $signed(tvsc_pkg::DSUM_BITS'(cfg.base_delay))
              + tvsc_pkg::DSUM_BITS'(lfo_off);
      if (del_sum < tvsc_pkg::DEL_LO) begin
         del_c = tvsc_pkg::TAPD_BITS'(tvsc_pkg::DEL_LO);
      end else if (del_sum > tvsc_pkg::DEL_HI) begin
         del_c = tvsc_pkg::TAPD_BITS'(tvsc_pkg::DEL_HI);
      end else begin
         del_c = del_sum[tvsc_pkg::TAPD_BITS-1:0];
      end
      p0 = wi_ff - del_c[tvsc_pkg::TAPD_BITS-1:tvsc_pkg::FRAC_BITS];
      p1 = p0 - tvsc_pkg::DELAY_AW'(1);
   end

   assign rd_addr = ctl.addr ? p0 : p1_ff;

   tvsc_delay_ram #(
      .DEPTH (tvsc_pkg::DELAY_DEPTH),
      .WIDTH (tvsc_pkg::SAMPLE_BITS)
   ) u_line (
      .clock   (clock),
      .wr_en   (take),
      .wr_addr (wi_ff),
      .wr_data (req_ch.sample_in),
      .rd_en   (ctl.addr || ctl.rd0),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // interpolation and mix arithmetic
   always_comb begin
      if (ctl.rd0) begin
         d_masked = vld0_ff ? rd_data : '0;
      end else begin
         d_masked = vld1_ff ? rd_data : '0;
      end
      wgt_lo  = $signed(tvsc_pkg::WGT_ONE - tvsc_pkg::WGT_BITS'(frac_ff));
      wgt_hi  = $signed(tvsc_pkg::WGT_BITS'(frac_ff));
      tap_sum = acc_ff + d_masked * wgt_hi;
      tap     = tap_sum[tvsc_pkg::ACC_BITS-1:tvsc_pkg::FRAC_BITS];

      div_sel = chan_ff ? sum_r_ff : sum_l_ff;
      div_abs = div_sel[tvsc_pkg::SUM_BITS-1] ? -div_sel : div_sel;
      quo     = qprod_ff[tvsc_pkg::QPROD_BITS-1:tvsc_pkg::RECIP_SHIFT];
      quo_pos = $signed({1'b0, quo});
      quo_s   = qneg_ff ? -quo_pos : quo_pos;

      mix_tot = dry_prod_ff + wet_prod_ff + tvsc_pkg::MIX_ROUND;
      mix_q   = mix_tot[tvsc_pkg::MIX_BITS-1:tvsc_pkg::MIX_SHIFT];
      if (mix_q > tvsc_pkg::OUT_MAX) begin
         mix_sat = tvsc_pkg::SAMPLE_MAX;
      end else if (mix_q < tvsc_pkg::OUT_MIN) begin
         mix_sat = tvsc_pkg::SAMPLE_MIN;
      end else begin
         mix_sat = mix_q[tvsc_pkg::SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         x_ff     <= req_ch.sample_in;
         sum_l_ff <= '0;
         sum_r_ff <= '0;
      end
      if (ctl.sine) begin
         sine_ff     <= tvsc_pkg::SINE_TAB[phase_ff[voice_ff][tvsc_pkg::PHASE_BITS-1 -:
                                                               tvsc_pkg::SINE_AW]];
         dry_prod_ff <= $signed({1'b0, cfg.dry}) * x_ff;
      end
      if (ctl.mul) begin
         mprod_ff <= sine_ff * $signed({1'b0, cfg.mod_depth});
      end
      if (ctl.addr) begin
         frac_ff <= del_c[tvsc_pkg::FRAC_BITS-1:0];
         p1_ff   <= p1;
         vld0_ff <= wrap_ff || (p0 <= wi_ff);
         vld1_ff <= wrap_ff || (p1 <= wi_ff);
      end
      if (ctl.rd0) begin
         acc_ff <= d_masked * wgt_lo;
      end
      if (ctl.rd1) begin
         sum_l_ff <= sum_l_ff + tap;
         if (voice_ff == tvsc_pkg::VOICE_BITS'(tvsc_pkg::INVERT_VOICE)) begin
            sum_r_ff <= sum_r_ff - tap;
         end else begin
            sum_r_ff <= sum_r_ff + tap;
         end
      end
      if (ctl.div) begin
         qprod_ff <= div_abs[tvsc_pkg::MAG_BITS-1:0] * tvsc_pkg::RECIP3;
         qneg_ff  <= div_sel[tvsc_pkg::SUM_BITS-1];
      end
      if (ctl.wet) begin
         wet_prod_ff <= $signed({1'b0, cfg.wet}) * quo_s;
      end
      if (ctl.out && !chan_ff) begin
         left_ff <= mix_sat;
      end
      if (finish) begin
         rsp_left_ff  <= left_ff;
         rsp_right_ff <= mix_sat;
      end
   end

   assign req_ch.ready     = ctl.take_ok;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.left_out  = rsp_left_ff;
   assign rsp_ch.right_out = rsp_right_ff;

   a_take_starts_voice0: assert property (@(posedge clock) disable iff (reset)
      take |=> (state_ff == tvsc_pkg::ST_SINE) && (voice_ff == '0)
               && (sum_l_ff == '0) && (sum_r_ff == '0))
      else $error("accepted word did not start at voice zero with cleared sums");

   a_voice_range: assert property (@(posedge clock) disable iff (reset)
      voice_ff <= tvsc_pkg::VOICE_BITS'(tvsc_pkg::NVOICES - 1))
      else $error("voice counter out of range");

   a_wi_moves_at_end: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (wi_ff != $past(wi_ff)))
         |-> (($past(state_ff) == tvsc_pkg::ST_OUT) && $past(chan_ff)))
      else $error("write index moved outside the final mix step");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> ($past(state_ff) == tvsc_pkg::ST_OUT))
      else $error("result word raised outside the final mix step");

endmodule

// ===== rtl/three_voice_stereo_chorus_top.sv =====
// Three-voice stereo chorus top level. Each accepted mono word is written into a
// 4096-entry delay-line ram; three lfo voices then read two adjacent entries each
// through the ram's single read port and interpolate, and the left and right
// dry/wet mixes go through one shared divide-by-three and mix unit. After a word
// is accepted in idle, each voice steps through a sine rom read, a depth multiply,
// the tap address and two ram reads, and each output channel through a divide, a
// wet multiply and the mix. The result register lets the next word in while a
// result is still waiting. The delay line needs no clearing pass after reset: a
// wrap flag and the write index mark entries never written, which read as zero.
// Configuration is written through csr_we, csr_index and csr_wdata; the user must
// write it only while the block is idle, as the block does not enforce this.
module three_voice_stereo_chorus_top (
   input  logic                                 clock,
   input  logic                                 reset,
   tvsc_req_if.sink                             req_ch,
   tvsc_rsp_if.source                           rsp_ch,
   input  logic                                 csr_we,
   input  logic [tvsc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tvsc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   tvsc_pkg::cfg_type cfg;

   tvsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tvsc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule
